// File: rtl/core/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, register indexes and reset values for the stack pop
// sequence checker.
// ----------------------------------------------------------------------------
package spsc_pkg;

  // width of values, registers and counters
  localparam int VAL_W = 11;

  // default stack depth
  localparam int DEF_MAX_LEN = 1024;

  // configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_LENGTH   = 1'b1;

  // register reset values
  localparam logic [VAL_W-1:0] CAPACITY_RESET = 11'd1024;
  localparam logic [VAL_W-1:0] LENGTH_RESET   = 11'd1024;

  // status handed from the sequencer to the verdict register
  typedef struct packed {
    logic             done;
    logic             verdict;
  } verdict_t;

endpackage

// File: rtl/core/spsc_ram.sv
// ----------------------------------------------------------------------------
// spsc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spsc_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/stack_pop_sequence_checker.sv
// ----------------------------------------------------------------------------
// stack_pop_sequence_checker
// Checks that a stream of popped values is a legal pop order for a bounded
// stack fed with 1, 2, ..., length; gives one verdict per sequence.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  input    | in_valid / in_stall       | popped_value [10:0]
//  output   | out_valid / out_stall     | sequence_valid
//  config   | cfg_we                    | cfg_index, cfg_data [10:0]
//
//  An item that pops the current top is accepted, evaluated, reloads the top
//  from the stack RAM and finishes; a pop that empties the stack skips the
//  reload. An item that pushes numbers below its own value is accepted,
//  evaluated, runs a push run that writes one stack entry per cycle into the
//  RAM, and finishes. Items after an error are accepted, evaluated and finished.
//  Reset is synchronous and clears the sequence state; the stack RAM needs no
//  clearing. A stalled verdict holds the last item of the next sequence in its finish state until taken.
// ----------------------------------------------------------------------------
module stack_pop_sequence_checker
  import spsc_pkg::*;
#(
  parameter int MAX_LEN = DEF_MAX_LEN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] popped_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             sequence_valid,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state;
  logic [VAL_W-1:0] capacity;
  logic [VAL_W-1:0] length;
  logic [VAL_W-1:0] target;
  logic [VAL_W-1:0] top;
  logic [VAL_W-1:0] size;
  logic [VAL_W:0]   next_push;
  logic             still_valid;
  logic [VAL_W-1:0] position;

  logic [VAL_W-1:0] len_eff;
  logic [VAL_W:0]   size_after;
  logic             top_match;
  logic             in_range;
  logic             overflow;
  logic             last_item;
  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  verdict_t         fin;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      length   <= LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data;
        CFG_LENGTH:   length   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // effective length: at least one, at most the stack depth
  always_comb begin
    if (length == '0) begin
      len_eff = VAL_W'(1);
    end else if (32'(length) > MAX_LEN) begin
      len_eff = VAL_W'(MAX_LEN);
    end else begin
      len_eff = length;
    end
  end

  // evaluation of one popped value
  assign top_match  = (size != '0) && (top == target);
  assign in_range   = (target != '0) && (target <= len_eff) && ({1'b0, target} >= next_push);
  assign size_after = {1'b0, size} + {1'b0, target} - next_push + (VAL_W+1)'(1);
  assign overflow   = size_after > {1'b0, capacity};
  assign last_item  = ({1'b0, position} + (VAL_W+1)'(1)) >= {1'b0, len_eff};

  // stack RAM accesses: push writes at size, pop reloads the entry below
  assign ram_we    = (state == S_PUSH);
  assign ram_waddr = AW'(size);
  assign ram_re    = (state == S_EVAL) && still_valid && top_match && (size > VAL_W'(1));
  assign ram_raddr = AW'(size - VAL_W'(2));

  spsc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (next_push[VAL_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // finish step: a verdict goes out when the output register is free
  assign fin.done    = (state == S_FIN) && !(last_item && out_valid && out_stall);
  assign fin.verdict = still_valid;

  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      size        <= '0;
      next_push   <= (VAL_W+1)'(1);
      still_valid <= 1'b1;
      position    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            target <= popped_value;
            state  <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (!still_valid) begin
            state <= S_FIN;
          end else if (top_match) begin
            size  <= size - VAL_W'(1);
            state <= (size > VAL_W'(1)) ? S_LOAD : S_FIN;
          end else if (in_range && !overflow) begin
            if ({1'b0, target} == next_push) begin
              next_push <= next_push + (VAL_W+1)'(1);
              state     <= S_FIN;
            end else begin
              state <= S_PUSH;
            end
          end else begin
            still_valid <= 1'b0;
            state       <= S_FIN;
          end
        end
        S_PUSH: begin
          size <= size + VAL_W'(1);
          if (next_push + (VAL_W+1)'(1) == {1'b0, target}) begin
            top       <= next_push[VAL_W-1:0];
            next_push <= next_push + (VAL_W+1)'(2);
            state     <= S_FIN;
          end else begin
            next_push <= next_push + (VAL_W+1)'(1);
          end
        end
        S_LOAD: begin
          top   <= ram_rdata;
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin.done) begin
            state <= S_IDLE;
            if (last_item) begin
              size        <= '0;
              next_push   <= (VAL_W+1)'(1);
              still_valid <= 1'b1;
              position    <= '0;
            end else begin
              position <= position + VAL_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin.done && last_item) begin
      out_valid      <= 1'b1;
      sequence_valid <= fin.verdict;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // an accepted transfer is evaluated in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EVAL))
    else $error("accepted item not evaluated");

  // while the sequence is valid, the stack never holds more entries than numbers pushed
  assert property (@(posedge clk) disable iff (rst)
    still_valid |-> ({1'b0, size} < next_push))
    else $error("stack size exceeds pushed count");

  // a push run stops before the target value itself
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (next_push < {1'b0, target}))
    else $error("push run passed its target");

  // a new verdict only comes from the finish step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("verdict raised outside finish step");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the stack pop sequence checker. Drives claimed pop orders
// through the valid/stall input port, predicts each sequence verdict with a
// behavioral stack model and compares every verdict transfer against it.
// ----------------------------------------------------------------------------
module tb_top;
  import spsc_pkg::*;

  localparam int MAX_LEN     = DEF_MAX_LEN;
  localparam int VAL_MAX     = (1 << VAL_W) - 1;
  // one item may push up to MAX_LEN numbers, one per cycle, plus overhead
  localparam int IDLE_WAIT   = MAX_LEN + 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {SHAPE_LEGAL, SHAPE_SWAP, SHAPE_BAD_VALUE, SHAPE_WIDE_STACK,
                    SHAPE_NOISE} shape_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] popped_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             sequence_valid;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_CAPACITY;
  logic [VAL_W-1:0] cfg_data = '0;

  // stack model state and its copy of the registers
  logic [VAL_W-1:0] cap_reg;
  logic [VAL_W-1:0] len_reg;
  logic [VAL_W-1:0] model_stack [MAX_LEN];
  int               model_depth;
  int               model_next;
  logic             model_ok;
  int               model_count;

  logic             expected_verdicts [$];
  logic             exp_verdict;
  logic [VAL_W-1:0] pop_order [$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               fail_count = 0;
  int               cycle_count = 0;

  stack_pop_sequence_checker #(.MAX_LEN(MAX_LEN)) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .popped_value   (popped_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sequence_valid (sequence_valid),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // verdict check on every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("sequence_valid transfer with none expected: actual %0b", sequence_valid);
        fail_count++;
      end else begin
        exp_verdict = expected_verdicts.pop_front();
        if (sequence_valid !== exp_verdict) begin
          $error("sequence_valid mismatch: expected %0b, actual %0b",
                 exp_verdict, sequence_valid);
          fail_count++;
        end
      end
    end
  end

  function automatic int eff_length();
    if (len_reg == 0) return 1;
    if (len_reg > MAX_LEN) return MAX_LEN;
    return len_reg;
  endfunction

  function automatic int eff_capacity();
    return (cap_reg > MAX_LEN) ? MAX_LEN : cap_reg;
  endfunction

  function automatic void clear_sequence();
    model_depth = 0;
    model_next  = 1;
    model_ok    = 1'b1;
    model_count = 0;
  endfunction

  // push numbers until the top matches, then pop; verdict on the last item
  function automatic void predict_pop(input logic [VAL_W-1:0] value);
    int len;
    int cap;
    len = eff_length();
    cap = eff_capacity();
    if (model_ok) begin
      while ((model_depth == 0 || model_stack[model_depth-1] != value) &&
             model_next <= len) begin
        if (model_depth < MAX_LEN) model_stack[model_depth] = model_next[VAL_W-1:0];
        model_depth++;
        model_next++;
        if (model_depth > cap) begin
          model_ok = 1'b0;
          break;
        end
      end
      if (model_ok) begin
        if (model_depth == 0 || model_stack[model_depth-1] != value) model_ok = 1'b0;
        else model_depth--;
      end
    end
    model_count++;
    if (model_count >= len) begin
      expected_verdicts.push_back(model_ok);
      clear_sequence();
    end
  endfunction

  function automatic void set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 50; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;  recv_stall_pct = 50;
      end
      default: begin
        send_idle_pct = 24; recv_stall_pct = 24;
      end
    endcase
  endfunction

  // one input transfer; valid stays high afterwards unless the next call idles
  task automatic send_value(input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    popped_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pop(value);
  endtask

  task automatic send_order();
    foreach (pop_order[i]) send_value(pop_order[i]);
  endtask

  // hold the sender until every verdict has arrived
  task automatic wait_verdicts_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // block idle: no verdict pending and the last item surely finished
  task automatic settle_block();
    wait_verdicts_drained();
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [VAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    if (index == CFG_CAPACITY) cap_reg = data;
    else len_reg = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [VAL_W-1:0] cap, input logic [VAL_W-1:0] len);
    settle_block();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_LENGTH, len);
  endtask

  // random legal pop order that never holds more than cap entries
  task automatic make_legal_order(input int cap, input int len);
    int pending [$];
    int nxt;
    pop_order.delete();
    nxt = 1;
    while (pop_order.size() < len) begin
      if (pending.size() != 0 &&
          (nxt > len || pending.size() >= cap || $urandom_range(1) == 1)) begin
        pop_order.push_back(VAL_W'(pending.pop_back()));
      end else begin
        pending.push_back(nxt);
        nxt++;
      end
    end
  endtask

  // mostly legal orders with random content, the rest broken or noise
  task automatic build_order();
    int     len;
    int     cap;
    int     pick;
    int     a;
    int     b;
    logic [VAL_W-1:0] tmp;
    shape_t shape;
    len  = eff_length();
    cap  = (eff_capacity() == 0) ? 1 : eff_capacity();
    pick = $urandom_range(99);
    if (pick < 65)      shape = SHAPE_LEGAL;
    else if (pick < 75) shape = SHAPE_SWAP;
    else if (pick < 85) shape = SHAPE_BAD_VALUE;
    else if (pick < 93) shape = SHAPE_WIDE_STACK;
    else                shape = SHAPE_NOISE;
    if (shape == SHAPE_WIDE_STACK) make_legal_order(cap + 1 + $urandom_range(2), len);
    else make_legal_order(cap, len);
    a = $urandom_range(len - 1);
    b = $urandom_range(len - 1);
    case (shape)
      SHAPE_SWAP: begin
        tmp          = pop_order[a];
        pop_order[a] = pop_order[b];
        pop_order[b] = tmp;
      end
      SHAPE_BAD_VALUE: begin
        if ($urandom_range(1) == 1) pop_order[a] = VAL_W'($urandom_range(VAL_MAX));
        else pop_order[a] = ($urandom_range(1) == 1) ? VAL_W'(0) : VAL_W'(len + 1);
      end
      SHAPE_NOISE: begin
        foreach (pop_order[i]) pop_order[i] = VAL_W'($urandom_range(VAL_MAX));
      end
      default: ;
    endcase
  endtask

  // ordinary legal and illegal orders for a small stack
  task automatic test_legal_orders();
    configure(11'd3, 11'd3);
    pop_order = '{1, 2, 3};  send_order();
    pop_order = '{3, 2, 1};  send_order();
    pop_order = '{2, 3, 1};  send_order();
    pop_order = '{3, 1, 2};  send_order();
  endtask

  // zero, above the length and the top code never match a stacked number
  task automatic test_out_of_range_values();
    pop_order = '{0, 1, 2};        send_order();
    pop_order = '{1, 2, VAL_MAX};  send_order();
    pop_order = '{1, 2, 4};        send_order();
  endtask

  // overflow of a one-entry stack and a zero-capacity stack
  task automatic test_capacity_limits();
    configure(11'd1, 11'd3);
    pop_order = '{1, 2, 3};  send_order();
    pop_order = '{2, 1, 3};  send_order();
    configure(11'd0, 11'd1);
    pop_order = '{1};        send_order();
  endtask

  // length zero acts as one; capacity above the stack depth saturates
  task automatic test_length_extremes();
    configure(11'd2047, 11'd0);
    pop_order = '{1};        send_order();
    pop_order = '{0};        send_order();
    pop_order = '{VAL_MAX};  send_order();
  endtask

  // register writes between items of one sequence
  task automatic test_mid_sequence_update();
    configure(11'd4, 11'd4);
    pop_order = '{2, 1};  send_order();
    settle_block();
    write_reg(CFG_LENGTH, 11'd3);
    pop_order = '{3};     send_order();
    configure(11'd4, 11'd4);
    pop_order = '{1};     send_order();
    settle_block();
    write_reg(CFG_CAPACITY, 11'd1);
    pop_order = '{3, 2, 4};  send_order();
  endtask

  task automatic run_random_phase(input logic [VAL_W-1:0] cap, input logic [VAL_W-1:0] len,
                                  input idle_mode_t mode, input int target);
    int sent;
    int seq_no;
    configure(cap, len);
    set_idle_mode(mode);
    sent   = 0;
    seq_no = 0;
    while (sent < target) begin
      build_order();
      send_order();
      sent += pop_order.size();
      if (seq_no == 0 || $urandom_range(7) == 0) wait_verdicts_drained();
      seq_no++;
    end
    set_idle_mode(IDLE_NONE);
  endtask

  // one full-depth sequence, then many short ones under every idle pattern
  task automatic test_random_traffic();
    logic [VAL_W-1:0] cap;
    logic [VAL_W-1:0] len;
    run_random_phase(11'd1024, 11'd2047, IDLE_BOTH, 1);
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: begin cap = 11'd2047; len = 11'd12; end
        1: begin cap = 11'd1;    len = 11'd8;  end
        2: begin cap = 11'd2;    len = 11'd10; end
        3: begin cap = 11'd0;    len = 11'd5;  end
        4: begin cap = 11'd4;    len = 11'd1;  end
        5: begin cap = 11'd1024; len = 11'd20; end
        default: begin
          cap = VAL_W'($urandom_range(1, 12));
          len = VAL_W'($urandom_range(1, 24));
        end
      endcase
      run_random_phase(cap, len, idle_mode_t'(p % 4), 50);
    end
  endtask

  initial begin
    cap_reg = CAPACITY_RESET;
    len_reg = LENGTH_RESET;
    clear_sequence();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_legal_orders();
    test_out_of_range_values();
    test_capacity_limits();
    test_length_extremes();
    test_mid_sequence_update();
    test_random_traffic();

    // drain, then watch for stray verdicts
    settle_block();
    if (expected_verdicts.size() != 0) begin
      $error("%0d sequence_valid transfers never arrived", expected_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
